// ===== sv/ecbt_pkg.sv =====
// Shared types and constants for the event control block table.
`timescale 1ns / 1ps

package ecbt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [31:0] HANDLE_BASE = 32'hf100_0000;
    localparam logic [15:0] HANDLE_TAG  = 16'hf100;
    localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;

    localparam logic [1:0] MODE_CALLBACK = 2'd1;
    localparam logic [1:0] MODE_MARK     = 2'd2;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_BAD_HANDLE = 2'd1;
    localparam logic [1:0] ERR_NOT_READY  = 2'd2;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_DISABLED = 2'd1,
        ST_ENABLED  = 2'd2,
        ST_READY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_OPEN    = 3'd0,
        OP_CLOSE   = 3'd1,
        OP_WAIT    = 3'd2,
        OP_TEST    = 3'd3,
        OP_ENABLE  = 3'd4,
        OP_DISABLE = 3'd5,
        OP_DELIVER = 3'd6
    } t_op;

    typedef struct packed {
        t_status     status;
        logic [31:0] cls;
        logic [31:0] spec;
        logic [1:0]  mode;
        logic [31:0] handler;
    } t_entry;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] cls;
        logic [31:0] spec;
        logic [1:0]  mode;
        logic [31:0] handler;
        logic        hit;
        logic        claim_ok;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic took;
        logic ready_hit;
    } t_flags;

endpackage

// ===== sv/ecbt_cell.sv =====
// One table entry held in the rotating ring of cells.
`timescale 1ns / 1ps

module ecbt_cell
    import ecbt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.status <= ST_FREE;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== sv/ecbt_proc.sv =====
// Applies the current call to the entry leaving the head of the ring.
`timescale 1ns / 1ps

module ecbt_proc
    import ecbt_pkg::*;
(
    input  t_entry i_entry,
    input  t_cmd   i_cmd,
    output t_entry o_entry,
    output t_flags o_flags
);

    logic w_match;

    assign w_match = (i_entry.status == ST_ENABLED) && (i_entry.cls == i_cmd.cls) &&
                     (i_entry.spec == i_cmd.spec);

    always_comb begin
        o_entry = i_entry;
        o_flags = '0;
        unique case (i_cmd.op) inside
            OP_OPEN: begin
                if (i_entry.status == ST_FREE && i_cmd.claim_ok) begin
                    o_entry.status  = ST_DISABLED;
                    o_entry.cls     = i_cmd.cls;
                    o_entry.spec    = i_cmd.spec;
                    o_entry.mode    = i_cmd.mode;
                    o_entry.handler = i_cmd.handler;
                    o_flags.took    = 1'b1;
                end
            end
            OP_CLOSE: begin
                if (i_cmd.hit) begin
                    o_entry.status = ST_FREE;
                end
            end
            OP_WAIT, OP_TEST: begin
                if (i_cmd.hit && i_entry.status == ST_READY) begin
                    o_entry.status  = ST_ENABLED;
                    o_flags.ready_hit = 1'b1;
                end
            end
            OP_ENABLE, OP_DISABLE: begin
                if (i_cmd.hit && i_entry.status != ST_FREE) begin
                    o_entry.status = (i_cmd.op == OP_ENABLE) ? ST_ENABLED : ST_DISABLED;
                end
            end
            OP_DELIVER: begin
                if (w_match) begin
                    if (i_entry.mode == MODE_CALLBACK && i_entry.handler != 32'd0) begin
                        o_flags.emit = 1'b1;
                    end else if (i_entry.mode == MODE_MARK) begin
                        o_entry.status = ST_READY;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/event_control_block_table_unit.sv =====
// Event control block table: ring of entry cells scanned once per call.
// A call is accepted in the idle state and scanned over a full rotation of the ring; the
// finish state then loads its completion word and returns to idle for the next call.
// No new call is taken until the current one completes: the input stalls outside idle.
// Output stall pauses the rotation; each callback handler word is emitted during the scan.
// Reset clears every entry status to free and empties the output register.
`timescale 1ns / 1ps

module event_control_block_table_unit
    import ecbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_event_handle,
    input  logic [31:0] i_event_class,
    input  logic [31:0] i_event_spec,
    input  logic [1:0]  i_mode_code,
    input  logic [31:0] i_handler_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [2:0]        r_op;
    logic [31:0]       r_cls;
    logic [31:0]       r_spec;
    logic [1:0]        r_mode;
    logic [31:0]       r_handler;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_step;
    logic              r_found;
    logic [31:0]       r_value;
    logic [1:0]        r_err;

    logic              w_can_load;
    logic              w_load;
    logic              w_shift;
    logic              w_last_step;
    logic              w_handle_ok;
    logic [31:0]       n_value;
    logic [1:0]        n_err;
    t_cmd              w_cmd;
    t_flags            w_flags;
    t_entry            w_head;
    t_entry            w_back;
    t_entry            w_ring [TABLE_ENTRIES];

    assign w_can_load  = !o_out_valid || !i_out_stall;
    assign w_load      = w_can_load && ((r_state == S_FINISH) ||
                                        ((r_state == S_SCAN) && w_flags.emit));
    assign w_shift     = (r_state == S_SCAN) && w_can_load;
    assign w_last_step = (r_step == SLOT_W'(TABLE_ENTRIES - 1));
    assign o_in_stall  = (r_state != S_IDLE);

    assign w_handle_ok = (i_event_handle[31:16] == HANDLE_TAG) &&
                         (i_event_handle[15:0] < 16'(TABLE_ENTRIES));

    always_comb begin
        n_value = 32'd0;
        n_err   = ERR_OK;
        unique case (i_opcode) inside
            OP_OPEN: begin
                n_value = ALL_ONES;
            end
            OP_CLOSE, OP_ENABLE, OP_DISABLE: begin
                n_value = 32'd1;
            end
            OP_WAIT: begin
                n_err = w_handle_ok ? ERR_NOT_READY : ERR_BAD_HANDLE;
            end
            OP_TEST: begin
                n_err = w_handle_ok ? ERR_OK : ERR_BAD_HANDLE;
            end
            default: begin
            end
        endcase
    end

    assign w_cmd.op       = r_op;
    assign w_cmd.cls      = r_cls;
    assign w_cmd.spec     = r_spec;
    assign w_cmd.mode     = r_mode;
    assign w_cmd.handler  = r_handler;
    assign w_cmd.hit      = r_hit && (r_step == r_slot);
    assign w_cmd.claim_ok = !r_found;

    assign w_head = w_ring[TABLE_ENTRIES-1];

    ecbt_proc u_proc (
        .i_entry (w_head),
        .i_cmd   (w_cmd),
        .o_entry (w_back),
        .o_flags (w_flags)
    );

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        ecbt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry ((k == 0) ? w_back : w_ring[(k == 0) ? 0 : k - 1]),
            .o_entry (w_ring[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            o_out_valid <= w_load || (o_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op      <= i_opcode;
                        r_cls     <= i_event_class;
                        r_spec    <= i_event_spec;
                        r_mode    <= i_mode_code;
                        r_handler <= i_handler_address;
                        r_hit     <= w_handle_ok;
                        r_slot    <= i_event_handle[SLOT_W-1:0];
                        r_step    <= '0;
                        r_found   <= 1'b0;
                        r_value   <= n_value;
                        r_err     <= n_err;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_can_load) begin
                        if (w_flags.emit) begin
                            o_result_kind  <= 1'b1;
                            o_result_value <= w_head.handler;
                            o_error_code   <= ERR_OK;
                            o_last         <= 1'b0;
                        end
                        if (w_flags.took) begin
                            r_found <= 1'b1;
                            r_value <= HANDLE_BASE | 32'(r_step);
                        end
                        if (w_flags.ready_hit) begin
                            r_value <= 32'd1;
                            r_err   <= ERR_OK;
                        end
                        if (w_last_step) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_step <= r_step + SLOT_W'(1);
                        end
                    end
                end
                S_FINISH: begin
                    if (w_can_load) begin
                        o_result_kind  <= 1'b0;
                        o_result_value <= r_value;
                        o_error_code   <= r_err;
                        o_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_handler_only_on_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind) |-> (r_op == OP_DELIVER))
        else $error("handler word outside a deliver call");

    a_handler_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind) |-> !o_last)
        else $error("handler word marked as last");

    a_error_on_completion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_code != ERR_OK)) |-> (o_last && !o_result_kind))
        else $error("error code on a non-completion word");

    a_full_rotation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && $past(r_state == S_SCAN)) |->
            $past(r_step == SLOT_W'(TABLE_ENTRIES - 1)))
        else $error("scan finished before a full rotation");

endmodule

// ===== verif/ecbt_checker.sv =====
// Channel monitor, call predictor and word comparator for the event control block table.
`timescale 1ns / 1ps

module ecbt_checker
    import ecbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_event_handle,
    input  logic [31:0] i_event_class,
    input  logic [31:0] i_event_spec,
    input  logic [1:0]  i_mode_code,
    input  logic [31:0] i_handler_address,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_result_kind,
    input  logic [31:0] i_result_value,
    input  logic [1:0]  i_error_code,
    input  logic        i_last,
    output int          o_pending,
    output int          o_failures
);

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [1:0]  err;
        logic        last;
    } t_word;

    t_status     ecb_status  [TABLE_ENTRIES];
    logic [31:0] ecb_class   [TABLE_ENTRIES];
    logic [31:0] ecb_spec    [TABLE_ENTRIES];
    logic [1:0]  ecb_mode    [TABLE_ENTRIES];
    logic [31:0] ecb_handler [TABLE_ENTRIES];

    t_word awaited_words[$];
    int    failures = 0;

    function automatic void push_word(input logic kind, input logic [31:0] value,
                                      input logic [1:0] err, input logic last);
        awaited_words.push_back({kind, value, err, last});
    endfunction

    function automatic void predict_call(input logic [2:0] op, input logic [31:0] handle,
                                         input logic [31:0] cls, input logic [31:0] spec,
                                         input logic [1:0] mode, input logic [31:0] handler);
        logic handle_ok;
        logic found;
        int   slot;
        handle_ok = (handle[31:16] == HANDLE_TAG) && (handle[15:0] < TABLE_ENTRIES);
        slot      = handle_ok ? int'(handle[15:0]) : 0;
        found     = 1'b0;
        case (op)
            OP_OPEN: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (!found && ecb_status[i] == ST_FREE) begin
                        found          = 1'b1;
                        ecb_status[i]  = ST_DISABLED;
                        ecb_class[i]   = cls;
                        ecb_spec[i]    = spec;
                        ecb_mode[i]    = mode;
                        ecb_handler[i] = handler;
                        push_word(1'b0, HANDLE_BASE | 32'(i), ERR_OK, 1'b1);
                    end
                end
                if (!found) begin
                    push_word(1'b0, ALL_ONES, ERR_OK, 1'b1);
                end
            end
            OP_CLOSE: begin
                if (handle_ok) begin
                    ecb_status[slot] = ST_FREE;
                end
                push_word(1'b0, 32'd1, ERR_OK, 1'b1);
            end
            OP_WAIT, OP_TEST: begin
                if (!handle_ok) begin
                    push_word(1'b0, 32'd0, ERR_BAD_HANDLE, 1'b1);
                end else if (ecb_status[slot] == ST_READY) begin
                    ecb_status[slot] = ST_ENABLED;
                    push_word(1'b0, 32'd1, ERR_OK, 1'b1);
                end else begin
                    push_word(1'b0, 32'd0, (op == OP_WAIT) ? ERR_NOT_READY : ERR_OK, 1'b1);
                end
            end
            OP_ENABLE, OP_DISABLE: begin
                if (handle_ok && ecb_status[slot] != ST_FREE) begin
                    ecb_status[slot] = (op == OP_ENABLE) ? ST_ENABLED : ST_DISABLED;
                end
                push_word(1'b0, 32'd1, ERR_OK, 1'b1);
            end
            OP_DELIVER: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (ecb_status[i] == ST_ENABLED && ecb_class[i] == cls
                            && ecb_spec[i] == spec) begin
                        if (ecb_mode[i] == MODE_CALLBACK && ecb_handler[i] != 32'd0) begin
                            push_word(1'b1, ecb_handler[i], ERR_OK, 1'b0);
                        end else if (ecb_mode[i] == MODE_MARK) begin
                            ecb_status[i] = ST_READY;
                        end
                    end
                end
                push_word(1'b0, 32'd0, ERR_OK, 1'b1);
            end
            default: begin
                push_word(1'b0, 32'd0, ERR_OK, 1'b1);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                ecb_status[i] = ST_FREE;
            end
            awaited_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_result_kind, i_result_value, i_error_code, i_last};
                if (awaited_words.size() == 0) begin
                    failures++;
                    $display("%0t: word with none awaited: kind %0d value %h error %0d last %0d",
                             $time, got.kind, got.value, got.err, got.last);
                end else begin
                    want = awaited_words.pop_front();
                    if (got !== want) begin
                        failures++;
                        $display("%0t: expected k%0d v%h e%0d l%0d, got k%0d v%h e%0d l%0d",
                                 $time, want.kind, want.value, want.err, want.last,
                                 got.kind, got.value, got.err, got.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_call(i_opcode, i_event_handle, i_event_class, i_event_spec,
                             i_mode_code, i_handler_address);
            end
        end
        o_pending  <= awaited_words.size();
        o_failures <= failures;
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the event control block table bench: clock, reset, call stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import ecbt_pkg::*;

    localparam logic [2:0] OP_NONE   = 3'd7;
    localparam int         LONG_HOLD = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_opcode;
    logic [31:0] i_event_handle;
    logic [31:0] i_event_class;
    logic [31:0] i_event_spec;
    logic [1:0]  i_mode_code;
    logic [31:0] i_handler_address;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_result_kind;
    logic [31:0] o_result_value;
    logic [1:0]  o_error_code;
    logic        o_last;

    int pending;
    int failures;
    int idle_pct;
    int stall_pct;
    int hold_requests;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    event_control_block_table_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_event_handle    (i_event_handle),
        .i_event_class     (i_event_class),
        .i_event_spec      (i_event_spec),
        .i_mode_code       (i_mode_code),
        .i_handler_address (i_handler_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_result_value    (o_result_value),
        .o_error_code      (o_error_code),
        .o_last            (o_last)
    );

    ecbt_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_event_handle    (i_event_handle),
        .i_event_class     (i_event_class),
        .i_event_spec      (i_event_spec),
        .i_mode_code       (i_mode_code),
        .i_handler_address (i_handler_address),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_result_kind     (o_result_kind),
        .i_result_value    (o_result_value),
        .i_error_code      (o_error_code),
        .i_last            (o_last),
        .o_pending         (pending),
        .o_failures        (failures)
    );

    // hold off the output for a long stretch on request, else stall at random
    initial begin : out_stall_gen
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic issue_call(input logic [2:0] op, input logic [31:0] handle,
                              input logic [31:0] cls, input logic [31:0] spec,
                              input logic [1:0] mode, input logic [31:0] handler);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_opcode          <= op;
        i_event_handle    <= handle;
        i_event_class     <= cls;
        i_event_spec      <= spec;
        i_mode_code       <= mode;
        i_handler_address <= handler;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pool_value();
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return ALL_ONES;
            2:       return 32'h5a5a_a5a5;
            3:       return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_handle();
        int pick;
        pick = $urandom_range(9);
        if (pick < 7) begin
            return HANDLE_BASE | 32'($urandom_range(TABLE_ENTRIES - 1));
        end else if (pick == 7) begin
            return $urandom();
        end else if (pick == 8) begin
            return {HANDLE_TAG, 16'($urandom_range(65535, TABLE_ENTRIES))};
        end
        return {16'($urandom()), 16'($urandom_range(TABLE_ENTRIES - 1))};
    endfunction

    task automatic random_call();
        int          pick;
        logic [2:0]  op;
        logic [31:0] handler;
        pick = $urandom_range(99);
        if (pick < 30) begin
            op = OP_OPEN;
        end else if (pick < 42) begin
            op = OP_CLOSE;
        end else if (pick < 52) begin
            op = OP_WAIT;
        end else if (pick < 62) begin
            op = OP_TEST;
        end else if (pick < 77) begin
            op = OP_ENABLE;
        end else if (pick < 82) begin
            op = OP_DISABLE;
        end else if (pick < 96) begin
            op = OP_DELIVER;
        end else begin
            op = OP_NONE;
        end
        handler = ($urandom_range(7) == 0) ? 32'd0 : $urandom();
        issue_call(op, pick_handle(), pool_value(), pool_value(),
                   2'($urandom_range(3)), handler);
    endtask

    initial begin : stimulus
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_opcode          <= OP_OPEN;
        i_event_handle    <= 32'd0;
        i_event_class     <= 32'd0;
        i_event_spec      <= 32'd0;
        i_mode_code       <= 2'd0;
        i_handler_address <= 32'd0;
        stall_pct         <= 0;
        hold_requests     <= 0;
        idle_pct           = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_call(OP_OPEN, 32'd0, 32'd0, 32'd0, MODE_CALLBACK, ALL_ONES);
        issue_call(OP_OPEN, ALL_ONES, ALL_ONES, ALL_ONES, MODE_MARK, 32'd0);
        issue_call(OP_OPEN, 32'd0, 32'd0, 32'd0, MODE_CALLBACK, 32'd0);
        issue_call(OP_OPEN, 32'd0, 32'd0, 32'd0, 2'd3, 32'h0000_1234);
        issue_call(OP_OPEN, 32'd0, 32'd0, 32'd0, 2'd0, 32'h0000_5678);
        for (int s = 0; s < 5; s++) begin
            issue_call(OP_ENABLE, HANDLE_BASE | 32'(s), 32'd0, 32'd0, 2'd0, 32'd0);
        end
        issue_call(OP_DELIVER, 32'd0, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_DELIVER, 32'd0, ALL_ONES, ALL_ONES, 2'd0, 32'd0);
        issue_call(OP_TEST, HANDLE_BASE | 32'd1, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_WAIT, HANDLE_BASE | 32'd1, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_TEST, HANDLE_BASE, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_WAIT, HANDLE_BASE | 32'(TABLE_ENTRIES), 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_TEST, 32'h0000_0001, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_CLOSE, ALL_ONES, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_ENABLE, 32'h0f00_0002, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_DISABLE, HANDLE_BASE, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_NONE, ALL_ONES, ALL_ONES, ALL_ONES, 2'd3, ALL_ONES);
        issue_call(OP_CLOSE, HANDLE_BASE | 32'd1, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_ENABLE, HANDLE_BASE | 32'd1, 32'd0, 32'd0, 2'd0, 32'd0);
        issue_call(OP_DELIVER, 32'd0, 32'd0, 32'd0, 2'd0, 32'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 61;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 61;
                end
                default: begin
                    idle_pct = 12;
                    stall_pct <= 12;
                end
            endcase
            for (int n = 0; n < 100; n++) begin
                if (phase == 0 && n == 40) begin
                    hold_requests <= hold_requests + 1;
                end
                random_call();
            end
        end

        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
